// ----- hdl/hscd_pkg.sv -----
// Shared types and constants for the histogram scene change detector.
// Used by hscd_bin_path and histogram_scene_change_detector; no dependencies.
`timescale 1ns / 1ps

package hscd_pkg;

  // Threshold register: unsigned Q0.16.
  localparam int unsigned THR_W = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd19661;

  // Left side of the decision is sum * 2^15 (half the Q0.16 scale folded in).
  localparam int unsigned Q_SHIFT = 15;

  // Frame controller states.
  typedef enum logic [2:0] {
    ST_STREAM,
    ST_DRAIN,
    ST_MUL_T,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_DECIDE
  } hscd_state_e;

  // Per-frame result codes.
  typedef enum logic [1:0] {
    STATUS_NO_CHANGE = 2'd0,
    STATUS_REFERENCE = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_CHANGE    = 2'd3
  } hscd_status_e;

  // Reference control passed from the frame controller to the bin path.
  typedef struct packed {
    logic have_ref;
    logic ref_bank;
    logic clear_sum;
  } hscd_ref_ctrl_t;

endpackage

// ----- hdl/hscd_bin_path.sv -----
// Per-bin datapath: two-bank histogram memory, the |a*Tb - b*Ta| terms and
// the saturating distance accumulator. Depends on hscd_pkg.
`timescale 1ns / 1ps

module hscd_bin_path #(
  parameter int unsigned BIN_COUNT   = 256,
  parameter int unsigned COUNT_WIDTH = 24,
  parameter int unsigned SUM_W       = 57
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        bin_valid_i,
  input  logic [COUNT_WIDTH-1:0]      bin_count_i,
  input  logic [COUNT_WIDTH-1:0]      frame_total_i,
  input  logic                        last_bin_i,
  input  hscd_pkg::hscd_ref_ctrl_t    ref_ctrl_i,
  input  logic [COUNT_WIDTH-1:0]      ref_total_i,
  output logic [SUM_W-1:0]            sum_o,
  output logic                        done_o
);
  import hscd_pkg::*;

  localparam int unsigned POS_W     = $clog2(BIN_COUNT);
  localparam int unsigned DEPTH     = 2 * BIN_COUNT;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned PROD_W    = 2 * COUNT_WIDTH;
  localparam int unsigned SUM_EXT_W = SUM_W + 1;

  logic [POS_W-1:0]       pos_q, pos_d;
  logic [ADDR_W-1:0]      rd_addr, wr_addr;
  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data_q;

  logic                   v1_q, last1_q;
  logic [COUNT_WIDTH-1:0] b1_q, tb1_q;
  logic                   v2_q, last2_q;
  logic [PROD_W-1:0]      x_q, x_d, y_q, y_d;
  logic                   v3_q, last3_q;
  logic [PROD_W-1:0]      d_q, d_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SUM_EXT_W-1:0]   sum_ext;

  // Bin position wraps at the bin count and restarts after the final bin.
  always_comb begin
    pos_d = pos_q;
    if (bin_valid_i) begin
      if (last_bin_i || (pos_q == POS_W'(BIN_COUNT - 1))) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // Reads come from the reference bank, writes go to the other bank, so a
  // read and a write in the same cycle never touch the same entry.
  always_comb begin
    rd_addr = ref_ctrl_i.ref_bank ? ADDR_W'(BIN_COUNT) + ADDR_W'(pos_q) : ADDR_W'(pos_q);
    wr_addr = ref_ctrl_i.ref_bank ? ADDR_W'(pos_q) : ADDR_W'(BIN_COUNT) + ADDR_W'(pos_q);
  end

  // Histogram memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (bin_valid_i) begin
      mem[wr_addr] <= bin_count_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Cross products, zero while there is no reference.
  always_comb begin
    if (ref_ctrl_i.have_ref) begin
      x_d = PROD_W'(rd_data_q) * PROD_W'(tb1_q);
      y_d = PROD_W'(b1_q) * PROD_W'(ref_total_i);
    end else begin
      x_d = '0;
      y_d = '0;
    end
  end

  // Absolute difference of the two products.
  always_comb begin
    d_d = (x_q > y_q) ? x_q - y_q : y_q - x_q;
  end

  // Saturating accumulation; cleared once the frame has been decided.
  always_comb begin
    sum_ext = {1'b0, sum_q} + SUM_EXT_W'(d_q);
    sum_d   = sum_q;
    if (ref_ctrl_i.clear_sum) begin
      sum_d = '0;
    end else if (v3_q) begin
      sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end
  end

  // Control registers of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      v3_q    <= 1'b0;
      last3_q <= 1'b0;
      sum_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      v1_q    <= bin_valid_i;
      last1_q <= bin_valid_i && last_bin_i;
      v2_q    <= v1_q;
      last2_q <= last1_q;
      v3_q    <= v2_q;
      last3_q <= last2_q;
      sum_q   <= sum_d;
    end
  end

  // Payload registers of the pipeline.
  always_ff @(posedge clk_i) begin
    b1_q  <= bin_count_i;
    tb1_q <= frame_total_i;
    x_q   <= x_d;
    y_q   <= y_d;
    d_q   <= d_d;
  end

  assign sum_o  = sum_q;
  assign done_o = v3_q && last3_q;

endmodule

// ----- hdl/histogram_scene_change_detector.sv -----
// Histogram scene change detector: top level with the frame controller and
// the threshold product. Depends on hscd_pkg and hscd_bin_path.
`timescale 1ns / 1ps

// Bins stream in at one per cycle while the input is not stalled, bin 0 first,
// with last_bin_i on the final bin. The per-bin terms run through a four-stage
// path around the histogram memory (read, multiply, difference, accumulate).
// After the final bin the input stalls while that path drains, while the
// threshold * Ta * Tb product is built by one 16 x COUNT_WIDTH multiply and
// two half-width multiplies against Tb, then added and compared, and until
// the previous status has been taken. One status per frame is produced on the
// output; the next frame may stream in while that status still waits to be
// taken. The histogram memory holds two banks of BIN_COUNT entries and has no
// clearing pass: the user must see that only entries written by an earlier
// frame are ever used; the block itself does not enforce it.
module histogram_scene_change_detector #(
  parameter int unsigned BIN_COUNT   = 256,
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [COUNT_WIDTH-1:0]    bin_count_i,
  input  logic [COUNT_WIDTH-1:0]    frame_total_i,
  input  logic                      last_bin_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                frame_status_o,
  input  logic                      cfg_we_i,
  input  logic [hscd_pkg::THR_W-1:0] cfg_wdata_i
);
  import hscd_pkg::*;

  localparam int unsigned SUM_W  = 2 * COUNT_WIDTH + $clog2(BIN_COUNT) + 1;
  localparam int unsigned P_W    = THR_W + COUNT_WIDTH;
  localparam int unsigned LO_W   = (P_W + 1) / 2;
  localparam int unsigned PROD_W = LO_W + COUNT_WIDTH;
  localparam int unsigned RHS_W  = P_W + COUNT_WIDTH;
  localparam int unsigned CMP_W  = SUM_W + Q_SHIFT;

  hscd_state_e            state_q, state_d;
  logic [THR_W-1:0]       thr_q;
  logic                   have_ref_q;
  logic                   ref_bank_q;
  logic [COUNT_WIDTH-1:0] ref_total_q;
  logic [COUNT_WIDTH-1:0] tb_last_q;
  logic [P_W-1:0]         p_q;
  logic [PROD_W-1:0]      prod_q;
  logic [RHS_W-1:0]       rhs_q;
  logic                   out_valid_q;
  hscd_status_e           status_q, status_d;

  logic                   in_fire;
  logic                   out_free;
  logic                   decide_fire;
  logic                   take_ref;
  logic                   acc_done;
  logic [SUM_W-1:0]       sum;
  logic [CMP_W-1:0]       lhs_cmp, rhs_cmp;
  hscd_ref_ctrl_t         ref_ctrl;

  hscd_bin_path #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH),
    .SUM_W       (SUM_W)
  ) u_bin_path (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bin_valid_i   (in_fire),
    .bin_count_i   (bin_count_i),
    .frame_total_i (frame_total_i),
    .last_bin_i    (last_bin_i),
    .ref_ctrl_i    (ref_ctrl),
    .ref_total_i   (ref_total_q),
    .sum_o         (sum),
    .done_o        (acc_done)
  );

  // Frame decision: compare sum * 2^15 against threshold * Ta * Tb.
  always_comb begin
    lhs_cmp = {sum, {Q_SHIFT{1'b0}}};
    rhs_cmp = CMP_W'(rhs_q);
    if (tb_last_q == '0) begin
      status_d = STATUS_EMPTY;
    end else if (!have_ref_q) begin
      status_d = STATUS_REFERENCE;
    end else if (lhs_cmp > rhs_cmp) begin
      status_d = STATUS_CHANGE;
    end else begin
      status_d = STATUS_NO_CHANGE;
    end
  end

  // Next state of the frame controller.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_STREAM: begin
        if (in_fire && last_bin_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (acc_done) begin
          state_d = ST_MUL_T;
        end
      end
      ST_MUL_T:  state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_ADD;
      ST_ADD:    state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (out_free) begin
          state_d = ST_STREAM;
        end
      end
      default:   state_d = ST_STREAM;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready_o  = (state_q == ST_STREAM);
    in_fire     = in_valid_i && in_ready_o;
    out_free    = !out_valid_q || out_ready_i;
    decide_fire = (state_q == ST_DECIDE) && out_free;
    take_ref    = decide_fire &&
                  ((status_d == STATUS_NO_CHANGE) || (status_d == STATUS_REFERENCE));
    ref_ctrl.have_ref  = have_ref_q;
    ref_ctrl.ref_bank  = ref_bank_q;
    ref_ctrl.clear_sum = decide_fire;
  end

  // Control state, reference bookkeeping and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_STREAM;
      thr_q       <= THR_RESET;
      have_ref_q  <= 1'b0;
      ref_bank_q  <= 1'b0;
      ref_total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (take_ref) begin
        have_ref_q  <= 1'b1;
        ref_bank_q  <= ~ref_bank_q;
        ref_total_q <= tb_last_q;
      end
      if (decide_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Final-bin total, status register and the threshold product, built in registered steps.
  always_ff @(posedge clk_i) begin
    if (in_fire && last_bin_i) begin
      tb_last_q <= frame_total_i;
    end
    if (decide_fire) begin
      status_q <= status_d;
    end
    case (state_q)
      ST_MUL_T: begin
        p_q <= P_W'(thr_q) * P_W'(ref_total_q);
      end
      ST_MUL_LO: begin
        prod_q <= PROD_W'(p_q[LO_W-1:0]) * PROD_W'(tb_last_q);
      end
      ST_MUL_HI: begin
        rhs_q  <= RHS_W'(prod_q);
        prod_q <= PROD_W'(p_q[P_W-1:LO_W]) * PROD_W'(tb_last_q);
      end
      ST_ADD: begin
        rhs_q <= rhs_q + (RHS_W'(prod_q) << LO_W);
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = status_q;

  // The final bin reaches the accumulator only while the controller drains.
  a_done_in_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done |-> (state_q == ST_DRAIN))
    else $error("final bin accumulated outside the drain state");

  // No bin of the next frame is taken right after a final bin.
  a_stall_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_bin_i) |=> !in_ready_o)
    else $error("input accepted while a frame decision is pending");

  // The reference bank swaps only on a frame decision.
  a_bank_swap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ref_bank_q != $past(ref_bank_q)) |-> $past(decide_fire))
    else $error("reference bank changed without a decision");

  // The distance sum starts from zero after each decision.
  a_sum_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    decide_fire |=> (sum == '0))
    else $error("distance sum not cleared after a decision");

endmodule

// ----- tb/sv/tb_histogram_scene_change_detector.sv -----
// Self-checking testbench for histogram_scene_change_detector: a frame-level
// predictor class plus tasks that stream histograms through the valid/ready ports.
// Depends on hscd_pkg and the detector RTL.
`timescale 1ns / 1ps

// Predicts the status of each frame from the accepted bins and checks the
// statuses that come out of the block in order.
class scene_predictor;
  localparam int unsigned BINS = 256;
  localparam int unsigned CW = 24;
  localparam int unsigned REPORT_LIMIT = 10;

  // Two histogram banks; the incoming frame always goes to the non-reference one.
  logic [CW-1:0] hist [2][BINS];
  bit            filled [2][BINS];
  bit            ref_bank;
  logic [CW-1:0] ref_total;
  bit            have_ref;
  int unsigned   bin_pos;
  logic [63:0]   dist_sum;
  logic [15:0]   threshold;

  hscd_pkg::hscd_status_e status_due[$];
  int unsigned mismatches;
  int unsigned frames_checked;
  int unsigned bins_noted;
  int unsigned status_seen [4];

  function new();
    ref_bank       = 1'b0;
    ref_total      = '0;
    have_ref       = 1'b0;
    bin_pos        = 0;
    dist_sum       = '0;
    threshold      = hscd_pkg::THR_RESET;
    mismatches     = 0;
    frames_checked = 0;
    bins_noted     = 0;
  endfunction

  function void set_threshold(logic [15:0] value);
    threshold = value;
  endfunction

  // Longest frame that reads only reference entries that have been written.
  function int unsigned readable_bins();
    if (!have_ref) return 1 << 20;
    for (int unsigned i = 0; i < BINS; i++) begin
      if (!filled[ref_bank][i]) return i;
    end
    return 1 << 20;
  endfunction

  function bit has_reference();
    return have_ref;
  endfunction

  function logic [CW-1:0] ref_bin(int unsigned idx);
    return hist[ref_bank][idx % BINS];
  endfunction

  function logic [CW-1:0] ref_frame_total();
    return ref_total;
  endfunction

  function int unsigned pending();
    return status_due.size();
  endfunction

  // Called for every accepted bin transfer.
  function void note_bin(logic [CW-1:0] cnt, logic [CW-1:0] total, bit last);
    logic [63:0]  prod_ref;
    logic [63:0]  prod_new;
    logic [63:0]  diff;
    logic [63:0]  acc;
    logic [127:0] lhs;
    logic [127:0] rhs;
    bit           wr_bank;
    hscd_pkg::hscd_status_e st;

    wr_bank = ~ref_bank;
    bins_noted++;

    // Cross-multiplied difference keeps the normalization exact.
    if (have_ref) begin
      prod_ref = 64'(hist[ref_bank][bin_pos]) * 64'(total);
      prod_new = 64'(cnt) * 64'(ref_total);
      diff     = (prod_ref > prod_new) ? prod_ref - prod_new : prod_new - prod_ref;
      acc      = dist_sum + diff;
      dist_sum = (acc < dist_sum) ? '1 : acc;
    end
    hist[wr_bank][bin_pos]   = cnt;
    filled[wr_bank][bin_pos] = 1'b1;
    bin_pos = (bin_pos + 1) % BINS;
    if (!last) return;

    // Frame decision on the final bin.
    if (total == '0) begin
      st = hscd_pkg::STATUS_EMPTY;
    end else if (!have_ref) begin
      have_ref  = 1'b1;
      ref_bank  = wr_bank;
      ref_total = total;
      st        = hscd_pkg::STATUS_REFERENCE;
    end else begin
      lhs = {49'b0, dist_sum, 15'b0};
      rhs = 128'(threshold) * 128'(ref_total) * 128'(total);
      if (lhs > rhs) begin
        st = hscd_pkg::STATUS_CHANGE;
      end else begin
        ref_bank  = wr_bank;
        ref_total = total;
        st        = hscd_pkg::STATUS_NO_CHANGE;
      end
    end
    bin_pos  = 0;
    dist_sum = '0;
    status_due.push_back(st);
  endfunction

  // Called for every accepted status transfer.
  function void check_status(logic [1:0] got);
    hscd_pkg::hscd_status_e want;
    if (status_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("ERROR: frame status %0d arrived with no frame outstanding", got);
      return;
    end
    want = status_due.pop_front();
    frames_checked++;
    status_seen[int'(want)]++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("ERROR: frame %0d status expected %s (%0d), got %0d",
                 frames_checked, want.name(), want, got);
    end
  endfunction
endclass

module tb_histogram_scene_change_detector;
  import hscd_pkg::*;

  localparam int unsigned BINS = 256;
  localparam int unsigned CW = 24;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_BINS = 900;
  localparam int unsigned SEGMENTS = 6;

  typedef enum int unsigned {
    FR_SIMILAR,
    FR_SCALED,
    FR_RANDOM,
    FR_EMPTY,
    FR_DRIFT
  } frame_kind_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [CW-1:0]     bin_count_i;
  logic [CW-1:0]     frame_total_i;
  logic              last_bin_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [1:0]        frame_status_o;
  logic              cfg_we_i;
  logic [THR_W-1:0]  cfg_wdata_i;

  scene_predictor tracker;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    stall_cycles;
  int unsigned    thr_writes;

  histogram_scene_change_detector #(
    .BIN_COUNT   (BINS),
    .COUNT_WIDTH (CW)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .bin_count_i    (bin_count_i),
    .frame_total_i  (frame_total_i),
    .last_bin_i     (last_bin_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every status transfer is checked against the oldest pending frame.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_status(frame_status_o);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [CW-1:0] pick_count();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return CW'($urandom);
      3:       return CW'($urandom_range(255));
      default: return CW'($urandom_range(65535));
    endcase
  endfunction

  // Drives one bin and returns at the edge where it is transferred.
  task automatic send_bin(input logic [CW-1:0] cnt, input logic [CW-1:0] total,
                          input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    bin_count_i   <= cnt;
    frame_total_i <= total;
    last_bin_i    <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_bin(cnt, total, last);
  endtask

  task automatic send_uniform(input int unsigned len, input logic [CW-1:0] cnt,
                              input logic [CW-1:0] total, input logic [CW-1:0] last_total);
    for (int unsigned i = 0; i < len; i++) begin
      send_bin(cnt, (i == len - 1) ? last_total : total, i == len - 1);
    end
  endtask

  // One frame whose content is shaped by its kind.
  task automatic send_frame(input int unsigned len, input frame_kind_e kind);
    logic [CW-1:0] total;
    logic [CW-1:0] cnt;
    logic [CW-1:0] bin_total;
    logic [CW-1:0] noise_mask;
    frame_kind_e   shape;

    shape = kind;
    if (!tracker.has_reference() && (shape == FR_SIMILAR || shape == FR_SCALED))
      shape = FR_RANDOM;
    total = pick_count();
    if (total == '0) total = 1;
    noise_mask = CW'((1 << $urandom_range(12)) - 1);
    if (shape == FR_SIMILAR) total = tracker.ref_frame_total();
    if (shape == FR_SCALED) begin
      total = tracker.ref_frame_total() >> 1;
      if (total == '0) total = 1;
    end

    for (int unsigned i = 0; i < len; i++) begin
      bin_total = total;
      case (shape)
        FR_SIMILAR: cnt = tracker.ref_bin(i) ^ (CW'($urandom) & noise_mask);
        FR_SCALED:  cnt = tracker.ref_bin(i) >> 1;
        FR_DRIFT: begin
          cnt       = pick_count();
          bin_total = pick_count();
        end
        default:    cnt = pick_count();
      endcase
      // An empty frame is flagged by a zero total on its final bin.
      if (shape == FR_EMPTY && i == len - 1) bin_total = '0;
      send_bin(cnt, bin_total, i == len - 1);
    end
  endtask

  // Waits until every frame has reported and the block has gone quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_threshold(value);
    thr_writes++;
  endtask

  initial begin
    int unsigned       seg_end;
    int unsigned       len;
    int unsigned       pick;
    logic [THR_W-1:0]  thr;
    frame_kind_e       kind;

    tracker       = new();
    send_idle_pct = 21;
    recv_idle_pct = 74;
    thr_writes    = 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    bin_count_i   <= '0;
    frame_total_i <= '0;
    last_bin_i    <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    out_ready_i   <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at the reset threshold.
    send_uniform(1, '1, '0, '0);              // empty frame before any reference
    send_uniform(BINS, '1, '1, '1);           // first reference, all bins at maximum
    send_uniform(BINS + 258, '0, '1, '1);     // maximal distance, wraps and saturates
    send_uniform(3, 24'd1000, 24'd5000, '0);  // empty frame with a reference held
    send_uniform(5, '1, '1, '1);              // short frame, matches the reference
    send_frame(4, FR_DRIFT);                  // total changes from bin to bin
    send_uniform(1, '0, 24'd1, 24'd1);        // smallest nonempty frame

    // Random frames in segments, each with its own threshold; idling changes in segments 2 and 4.
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       thr = '0;
        1:       thr = '1;
        3:       thr = 16'd1;
        4:       thr = THR_RESET;
        default: thr = THR_W'($urandom);
      endcase
      write_threshold(thr);
      if (seg == 2) begin
        send_idle_pct = 74;
        recv_idle_pct = 21;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      seg_end = tracker.bins_noted + RANDOM_BINS / SEGMENTS;
      while (tracker.bins_noted < seg_end) begin
        pick = $urandom_range(99);
        if (pick < 4)      len = BINS;
        else if (pick < 6) len = BINS + $urandom_range(1, 40);
        else               len = $urandom_range(1, 24);
        if (len > tracker.readable_bins()) len = tracker.readable_bins();
        if (len == 0) len = 1;

        pick = $urandom_range(99);
        if (pick < 40)      kind = FR_SIMILAR;
        else if (pick < 55) kind = FR_SCALED;
        else if (pick < 75) kind = FR_RANDOM;
        else if (pick < 85) kind = FR_EMPTY;
        else                kind = FR_DRIFT;
        send_frame(len, kind);
      end
    end

    drain();
    $display("Streamed %0d bins; checked %0d frame statuses over %0d threshold settings.",
             tracker.bins_noted, tracker.frames_checked, thr_writes + 1);
    $display("Statuses: %0d no change, %0d reference, %0d empty, %0d scene change.",
             tracker.status_seen[0], tracker.status_seen[1],
             tracker.status_seen[2], tracker.status_seen[3]);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatches: %0d, frames still outstanding: %0d",
               tracker.mismatches, tracker.pending());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
